>>> rtl/core/pitep_pkg.sv
package pitep_pkg;

  localparam int PATH_W   = 20;
  localparam int VALUE_W  = 31;
  localparam int OFFSET_W = 20;
  localparam int COUNT_W  = 11;
  localparam int TADDR_W  = 10;
  localparam int POS_W    = 10;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 4;

  typedef enum logic [1:0] {
    CMD_LOAD_OFFSET = 2'd0,
    CMD_LOAD_START  = 2'd1,
    CMD_LOAD_TARGET = 2'd2,
    CMD_QUERY       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_PAIRWISE   = 2'd0,
    MODE_DIRECTED   = 2'd1,
    MODE_UNDIRECTED = 2'd2,
    MODE_GRID       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE         = 2'd0,
    REG_START_COUNT  = 2'd1,
    REG_TARGET_COUNT = 2'd2,
    REG_OFFSET_COUNT = 2'd3
  } reg_t;

  // divider result: quotient and remainder held until the next start; done is a strobe
  typedef struct packed {
    logic                done;
    logic [PATH_W-1:0]   quotient;
    logic [COUNT_W-1:0]  remainder;
  } div_res_t;

endpackage

>>> rtl/core/pitep_ram.sv
module pitep_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/pitep_div.sv
module pitep_div import pitep_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PATH_W-1:0]  dividend,
  input  logic [COUNT_W-1:0] divisor,
  output div_res_t           res
);

  localparam int CNT_W = $clog2(PATH_W);

  logic               busy;
  logic [CNT_W-1:0]   count;
  logic [PATH_W-1:0]  quo;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dvs;
  logic               done;

  logic [COUNT_W:0]   partial;
  logic               ge;

  // restoring division, one quotient bit per cycle
  assign partial = {rem, quo[PATH_W-1]};
  assign ge      = (partial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(PATH_W - 1);
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        quo <= {quo[PATH_W-2:0], ge};
        rem <= ge ? COUNT_W'(partial - {1'b0, dvs}) : partial[COUNT_W-1:0];
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

>>> rtl/core/path_index_to_endpoint_pair_unit.sv
// Loads: accepted while idle, no result. Query, acceptance to result valid: pairwise runs
// search probes (11 probes at most over 1024 offsets), one more step when no probe hits,
// then check, table read and finish; undirected adds the row offset fetch and a second
// start read; directed and grid use the 20-step divider instead; flagged ends early.
// One query in flight: input stalls until its result enters the output register.
// rst (synchronous) clears config registers and sequencer; table contents are not cleared.
module path_index_to_endpoint_pair_unit import pitep_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  // input transactions
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic [TADDR_W-1:0]  table_address,
  input  logic [VALUE_W-1:0]  load_value,
  input  logic [PATH_W-1:0]   path_index,
  input  logic [POS_W-1:0]    batch_position,
  // result transactions
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VALUE_W-1:0]  start_value,
  output logic [VALUE_W-1:0]  target_value,
  output logic                out_of_range,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int SRCH_W = COUNT_W + 2;   // signed lo/hi/mid of the search
  localparam int SI_W   = PATH_W + 2;    // signed start index (quotient or row)
  localparam int TI_W   = PATH_W + 3;    // signed target index

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SRCH_ADDR,
    S_SRCH_CMP,
    S_OFF_ADDR,
    S_OFF_WAIT,
    S_CHECK,
    S_RD_ADDR,
    S_RD_FIRST,
    S_RD_SECOND,
    S_FIN
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  mode_t              mode;
  logic [COUNT_W-1:0] start_count;
  logic [COUNT_W-1:0] target_count;
  logic [COUNT_W-1:0] offset_count;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_PAIRWISE;
      start_count  <= '0;
      target_count <= '0;
      offset_count <= '0;
    end else if (cfg_we) begin
      unique case (reg_t'(paddr[3:2]))
        REG_MODE:         mode         <= mode_t'(pwdata[1:0]);
        REG_START_COUNT:  start_count  <= pwdata[COUNT_W-1:0];
        REG_TARGET_COUNT: target_count <= pwdata[COUNT_W-1:0];
        REG_OFFSET_COUNT: offset_count <= pwdata[COUNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_t'(paddr[3:2]))
      REG_MODE:         prdata = {{(DATA_W-2){1'b0}}, mode};
      REG_START_COUNT:  prdata = {{(DATA_W-COUNT_W){1'b0}}, start_count};
      REG_TARGET_COUNT: prdata = {{(DATA_W-COUNT_W){1'b0}}, target_count};
      REG_OFFSET_COUNT: prdata = {{(DATA_W-COUNT_W){1'b0}}, offset_count};
    endcase
  end

  // counts beyond the table depth clip to it
  function automatic logic [COUNT_W-1:0] clip_count(input logic [COUNT_W-1:0] c);
    return (32'(c) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH) : c;
  endfunction

  logic [COUNT_W-1:0] ns, nt, no;
  assign ns = clip_count(start_count);
  assign nt = clip_count(target_count);
  assign no = clip_count(offset_count);

  // ---------------------------------------------------------------------------
  // Sequencer state and working registers
  // ---------------------------------------------------------------------------
  state_t                    state;
  logic [PATH_W-1:0]         q_path;
  logic signed [SRCH_W-1:0]  lo, hi, mid_q;
  logic signed [SI_W-1:0]    si;
  logic signed [TI_W-1:0]    ti;
  logic                      use_targets;
  logic                      bad;
  logic [VALUE_W-1:0]        res_start, res_target;

  logic                      in_take;
  logic                      load_take, query_take;
  logic                      addr_ok;
  cmd_t                      cmd;

  assign cmd        = cmd_t'(command);
  assign in_stall   = (state != S_IDLE);
  assign in_take    = in_valid & ~in_stall;
  assign query_take = in_take & (cmd == CMD_QUERY);
  assign load_take  = in_take & (cmd != CMD_QUERY);
  assign addr_ok    = (32'(table_address) < TABLE_DEPTH);

  // search midpoint; lo and hi are both non-negative whenever it is used
  logic signed [SRCH_W:0]   mid_sum;
  logic signed [SRCH_W-1:0] mid_c;
  assign mid_sum = (SRCH_W+1)'(lo) + (SRCH_W+1)'(hi);
  assign mid_c   = mid_sum[SRCH_W:1];

  // limits as signed values for the range check
  logic signed [SI_W-1:0] ns_si;
  logic signed [TI_W-1:0] tlim;
  assign ns_si = SI_W'($signed({1'b0, ns}));
  assign tlim  = use_targets ? TI_W'($signed({1'b0, nt})) : TI_W'($signed({1'b0, ns}));

  // ---------------------------------------------------------------------------
  // Shared divider: directed (path / (ns-1)) and grid (path / nt)
  // ---------------------------------------------------------------------------
  logic               div_start;
  logic [COUNT_W-1:0] div_divisor;
  div_res_t           div_res;

  assign div_start = query_take &
                     (((mode == MODE_DIRECTED) && (ns >= COUNT_W'(2))) ||
                      ((mode == MODE_GRID) && (nt != '0)));
  assign div_divisor = (mode == MODE_DIRECTED) ? ns - COUNT_W'(1) : nt;

  pitep_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (path_index),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  // ---------------------------------------------------------------------------
  // Tables
  // ---------------------------------------------------------------------------
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       off_raddr, start_raddr, tgt_raddr;
  logic [OFFSET_W-1:0] off_rdata;
  logic [VALUE_W-1:0]  start_rdata, tgt_rdata;

  assign wr_addr     = AW'(table_address);
  assign off_raddr   = (state == S_SRCH_ADDR) ? AW'(mid_c) : AW'(si);
  // second start read fetches the directed or undirected target row
  assign start_raddr = (state == S_RD_FIRST) ? AW'(ti) : AW'(si);
  assign tgt_raddr   = AW'(ti);

  pitep_ram #(.WIDTH(OFFSET_W), .DEPTH(TABLE_DEPTH)) u_off_ram (
    .clk   (clk),
    .we    (load_take & addr_ok & (cmd == CMD_LOAD_OFFSET)),
    .waddr (wr_addr),
    .wdata (load_value[OFFSET_W-1:0]),
    .raddr (off_raddr),
    .rdata (off_rdata)
  );

  pitep_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (load_take & addr_ok & (cmd == CMD_LOAD_START)),
    .waddr (wr_addr),
    .wdata (load_value),
    .raddr (start_raddr),
    .rdata (start_rdata)
  );

  pitep_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_tgt_ram (
    .clk   (clk),
    .we    (load_take & addr_ok & (cmd == CMD_LOAD_TARGET)),
    .waddr (wr_addr),
    .wdata (load_value),
    .raddr (tgt_raddr),
    .rdata (tgt_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state == S_FIN) & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // output register: cleared once taken, unless refilled the same cycle
      if (out_load) begin
        out_valid    <= 1'b1;
        start_value  <= bad ? '0 : res_start;
        target_value <= bad ? '0 : res_target;
        out_of_range <= bad;
      end else if (out_valid & ~out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (query_take) begin
            q_path      <= path_index;
            bad         <= 1'b0;
            use_targets <= (mode == MODE_PAIRWISE) || (mode == MODE_GRID);
            ti          <= (mode == MODE_PAIRWISE) ? TI_W'($signed({1'b0, batch_position}))
                                                   : '1;
            lo          <= '0;
            hi          <= SRCH_W'($signed({1'b0, no})) - SRCH_W'(1);
            unique case (mode)
              MODE_PAIRWISE, MODE_UNDIRECTED: state <= S_SRCH_ADDR;
              MODE_DIRECTED, MODE_GRID: begin
                if (div_start) begin
                  state <= S_DIV;
                end else begin
                  // too few starts (directed) or no targets (grid): no usable divisor
                  bad   <= 1'b1;
                  state <= S_FIN;
                end
              end
            endcase
          end
        end

        S_DIV: begin
          if (div_res.done) begin
            si <= SI_W'($signed({1'b0, div_res.quotient}));
            if ((mode == MODE_DIRECTED) &&
                ({1'b0, div_res.quotient} <= (PATH_W+1)'(div_res.remainder))) begin
              // skip the diagonal
              ti <= TI_W'(div_res.remainder) + TI_W'(1);
            end else begin
              ti <= TI_W'(div_res.remainder);
            end
            state <= S_CHECK;
          end
        end

        S_SRCH_ADDR: begin
          if (lo <= hi) begin
            mid_q <= mid_c;
            state <= S_SRCH_CMP;
          end else begin
            // no exact match: floor is hi, -1 when nothing lies below the path
            si <= SI_W'(hi);
            if ((mode == MODE_UNDIRECTED) && !hi[SRCH_W-1]) begin
              state <= S_OFF_ADDR;
            end else begin
              state <= S_CHECK;
            end
          end
        end

        S_SRCH_CMP: begin
          priority if (off_rdata == q_path) begin
            si    <= SI_W'(mid_q);
            state <= (mode == MODE_UNDIRECTED) ? S_OFF_ADDR : S_CHECK;
          end else if (off_rdata < q_path) begin
            lo    <= mid_q + SRCH_W'(1);
            state <= S_SRCH_ADDR;
          end else begin
            hi    <= mid_q - SRCH_W'(1);
            state <= S_SRCH_ADDR;
          end
        end

        S_OFF_ADDR: state <= S_OFF_WAIT;

        S_OFF_WAIT: begin
          // target row = path - offset[row] + row + 1
          ti <= TI_W'($signed({1'b0, q_path})) - TI_W'($signed({1'b0, off_rdata}))
                + TI_W'(si) + TI_W'(1);
          state <= S_CHECK;
        end

        S_CHECK: begin
          if (si[SI_W-1] || (si >= ns_si) || ti[TI_W-1] || (ti >= tlim)) begin
            bad   <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_RD_ADDR;
          end
        end

        S_RD_ADDR: state <= S_RD_FIRST;

        S_RD_FIRST: begin
          res_start <= start_rdata;
          if (use_targets) begin
            res_target <= tgt_rdata;
            state      <= S_FIN;
          end else begin
            state <= S_RD_SECOND;
          end
        end

        S_RD_SECOND: begin
          res_target <= start_rdata;
          state      <= S_FIN;
        end

        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/path_index_to_endpoint_pair_unit_tb.sv
`timescale 1ns / 100ps

module path_index_to_endpoint_pair_unit_tb;
  import pitep_pkg::*;

  localparam int DEPTH           = 1024;
  localparam int SETTLE_CYCLES   = 48;    // comfortably past the longest query latency
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off to back the block up
  localparam int WATCHDOG_LIMIT  = 6000;  // quiet cycles before the run is declared hung
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 42;

  // one input transaction as the block sees it
  typedef struct packed {
    cmd_t                cmd;
    logic [TADDR_W-1:0]  addr;
    logic [VALUE_W-1:0]  val;
    logic [PATH_W-1:0]   path;
    logic [POS_W-1:0]    pos;
  } stim_t;

  // one result transaction
  typedef struct packed {
    logic [VALUE_W-1:0]  start_v;
    logic [VALUE_W-1:0]  target_v;
    logic                flag;
  } endpoints_t;

  // directed rows: either a register write or a transaction; flagged rows carry
  // their expected result (all zero, out_of_range set) rather than using the predictor
  typedef struct {
    bit     is_reg;
    reg_t   reg_id;
    int     reg_value;
    stim_t  item;
    bit     flagged;
  } dir_row_t;

  localparam endpoints_t FLAGGED_RESULT = '{start_v: '0, target_v: '0, flag: 1'b1};

  // ---------------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [1:0]          command        = '0;
  logic [TADDR_W-1:0]  table_address  = '0;
  logic [VALUE_W-1:0]  load_value     = '0;
  logic [PATH_W-1:0]   path_index     = '0;
  logic [POS_W-1:0]    batch_position = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [VALUE_W-1:0]  start_value;
  logic [VALUE_W-1:0]  target_value;
  logic                out_of_range;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [PADDR_W-1:0]  paddr          = '0;
  logic [DATA_W-1:0]   pwdata         = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  path_index_to_endpoint_pair_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: shadow registers, shadow tables, and which entries have
  // been loaded since reset (so no query ever touches an unloaded entry)
  // ---------------------------------------------------------------------------
  mode_t               cfg_mode    = MODE_PAIRWISE;
  logic [COUNT_W-1:0]  cfg_starts  = '0;
  logic [COUNT_W-1:0]  cfg_targets = '0;
  logic [COUNT_W-1:0]  cfg_offsets = '0;

  logic [OFFSET_W-1:0] offset_mem [DEPTH];
  logic [VALUE_W-1:0]  start_mem  [DEPTH];
  logic [VALUE_W-1:0]  target_mem [DEPTH];
  bit                  offset_seen [DEPTH];
  bit                  start_seen  [DEPTH];
  bit                  target_seen [DEPTH];

  endpoints_t pending_endpoints [$];   // results owed by the block, oldest first
  int         mismatch_count = 0;

  // idling percentages for each side, set per phase
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // long hold-off requests: bumped by the stimulus, served by the receiver
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int quiet_cycles = 0;

  // counts above the table depth behave as the full depth
  function automatic int clip_count(logic [COUNT_W-1:0] c);
    return (int'(c) > DEPTH) ? DEPTH : int'(c);
  endfunction

  // Floor binary search over the loaded offsets. Classic left/right probing:
  // first exact hit wins (matters with equal offsets), otherwise the last row
  // below the path; -1 when no row qualifies.
  function automatic int row_floor(logic [PATH_W-1:0] path);
    int lo, hi, mid;
    bit found;
    lo    = 0;
    hi    = clip_count(cfg_offsets) - 1;
    mid   = 0;
    found = 1'b0;
    while (!found && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (offset_mem[mid] == path) found = 1'b1;
      else if (offset_mem[mid] < path) lo = mid + 1;
      else hi = mid - 1;
    end
    return found ? mid : hi;
  endfunction

  // Applies one accepted transaction to the shadow state; returns 1 with the
  // expected endpoints for a query, 0 for a load.
  function automatic bit decode_path(input stim_t s, output endpoints_t r);
    int ns, nt, si, ti, d;
    bit via_targets, bad, has;
    r           = '0;
    ns          = clip_count(cfg_starts);
    nt          = clip_count(cfg_targets);
    si          = -1;
    ti          = -1;
    via_targets = 1'b0;
    bad         = 1'b0;
    has         = 1'b0;
    case (s.cmd)
      CMD_LOAD_OFFSET: begin
        offset_mem[s.addr]  = s.val[OFFSET_W-1:0];
        offset_seen[s.addr] = 1'b1;
      end
      CMD_LOAD_START: begin
        start_mem[s.addr]  = s.val;
        start_seen[s.addr] = 1'b1;
      end
      CMD_LOAD_TARGET: begin
        target_mem[s.addr]  = s.val;
        target_seen[s.addr] = 1'b1;
      end
      default: begin
        has = 1'b1;
        case (cfg_mode)
          MODE_PAIRWISE: begin
            si          = row_floor(s.path);
            ti          = int'(s.pos);
            via_targets = 1'b1;
          end
          MODE_DIRECTED: begin
            // diagonal skipped: target index steps past the start index
            if (ns < 2) bad = 1'b1;
            else begin
              d  = ns - 1;
              si = int'(s.path) / d;
              ti = int'(s.path) % d;
              if (si <= ti) ti++;
            end
          end
          MODE_UNDIRECTED: begin
            si = row_floor(s.path);
            if (si >= 0) ti = int'(s.path) - int'(offset_mem[si]) + si + 1;
          end
          default: begin
            if (nt == 0) bad = 1'b1;
            else begin
              si          = int'(s.path) / nt;
              ti          = int'(s.path) % nt;
              via_targets = 1'b1;
            end
          end
        endcase
        if (!bad && (si < 0 || si >= ns || ti < 0 || ti >= (via_targets ? nt : ns)))
          bad = 1'b1;
        if (bad) r = FLAGGED_RESULT;
        else begin
          r.start_v  = start_mem[si];
          r.target_v = via_targets ? target_mem[ti] : start_mem[ti];
        end
      end
    endcase
    return has;
  endfunction

  // ---------------------------------------------------------------------------
  // Transaction builders; unused fields get random junk so every bit toggles
  // ---------------------------------------------------------------------------
  function automatic stim_t load_item(cmd_t c, int a, int v);
    stim_t s;
    s.cmd  = c;
    s.addr = TADDR_W'(a);
    s.val  = VALUE_W'(v);
    s.path = PATH_W'($urandom);
    s.pos  = POS_W'($urandom);
    return s;
  endfunction

  function automatic stim_t query_item(int p, int b);
    stim_t s;
    s.cmd  = CMD_QUERY;
    s.addr = TADDR_W'($urandom);
    s.val  = VALUE_W'($urandom);
    s.path = PATH_W'(p);
    s.pos  = POS_W'(b);
    return s;
  endfunction

  function automatic dir_row_t row_reg(reg_t r, int v);
    dir_row_t row;
    row.is_reg    = 1'b1;
    row.reg_id    = r;
    row.reg_value = v;
    row.item      = '0;
    row.flagged   = 1'b0;
    return row;
  endfunction

  function automatic dir_row_t row_load(cmd_t c, int a, int v);
    dir_row_t row;
    row           = row_reg(REG_MODE, 0);
    row.is_reg    = 1'b0;
    row.item      = load_item(c, a, v);
    return row;
  endfunction

  function automatic dir_row_t row_query(int p, int b, bit flagged = 1'b0);
    dir_row_t row;
    row           = row_reg(REG_MODE, 0);
    row.is_reg    = 1'b0;
    row.item      = query_item(p, b);
    row.flagged   = flagged;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // result side: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    endpoints_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_endpoints.size() == 0) begin
        log_mismatch("result transaction with nothing outstanding");
      end else begin
        want = pending_endpoints.pop_front();
        if (start_value !== want.start_v)
          log_mismatch($sformatf("start_value %h, want %h", start_value, want.start_v));
        if (target_value !== want.target_v)
          log_mismatch($sformatf("target_value %h, want %h", target_value, want.target_v));
        if (out_of_range !== want.flag)
          log_mismatch($sformatf("out_of_range %b, want %b", out_of_range, want.flag));
      end
    end
  end

  // receiver: random stall per phase, overridden by a long counted hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // watchdog: consecutive cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offers one transaction, holding it until accepted, then books what the
  // block owes for it. Idle gaps come before the offer, never under a stall.
  task automatic offer(input stim_t s, input bit flagged);
    endpoints_t pred;
    bit has;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    command        <= s.cmd;
    table_address  <= s.addr;
    load_value     <= s.val;
    path_index     <= s.path;
    batch_position <= s.pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = decode_path(s, pred);
    if (has) pending_endpoints.push_back(flagged ? FLAGGED_RESULT : pred);
  endtask

  // Block idle: nothing owed, plus a margin for a load still in the pipe
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_endpoints.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; bits above the field width are sometimes junk
  task automatic reg_write(input reg_t r, input int value);
    int w;
    logic [DATA_W-1:0] word;
    w    = (r == REG_MODE) ? 2 : COUNT_W;
    word = DATA_W'(value);
    if ($urandom_range(0, 1) != 0) word = word | ($urandom << w);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_MODE:         cfg_mode    = mode_t'(word[1:0]);
      REG_START_COUNT:  cfg_starts  = word[COUNT_W-1:0];
      REG_TARGET_COUNT: cfg_targets = word[COUNT_W-1:0];
      default:          cfg_offsets = word[COUNT_W-1:0];
    endcase
  endtask

  // loads random content into every entry below 'upto' not yet loaded
  task automatic fill_unwritten(input cmd_t c, input int upto);
    bit seen;
    for (int i = 0; i < upto; i++) begin
      case (c)
        CMD_LOAD_OFFSET: seen = offset_seen[i];
        CMD_LOAD_START:  seen = start_seen[i];
        default:         seen = target_seen[i];
      endcase
      if (!seen) offer(load_item(c, i, $urandom), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t rows [$];
    mode_t    pm;
    int       cls, n, cnt_s, cnt_t, cnt_o, eff_s, eff_t, eff_o;
    int       span, base, sel, p, b;
    bit       shaped;
    cmd_t     lc;

    // Directed table. Expected values typed in only for the flagged rows.
    rows.push_back(row_query(0, 0, 1'b1));                  // straight out of reset
    rows.push_back(row_load(CMD_LOAD_OFFSET, 0, 0));
    rows.push_back(row_load(CMD_LOAD_OFFSET, 1, 'h7FF00005)); // only low 20 bits kept
    rows.push_back(row_load(CMD_LOAD_START, 0, 'h7FFFFFFF));
    rows.push_back(row_load(CMD_LOAD_START, 1, 0));
    rows.push_back(row_load(CMD_LOAD_TARGET, 0, 'h1234));
    rows.push_back(row_load(CMD_LOAD_TARGET, 1, 'h7FFFFFFF));
    rows.push_back(row_load(CMD_LOAD_START, DEPTH - 1, 'h2AAAAAAA)); // top address
    rows.push_back(row_reg(REG_START_COUNT, 2));
    rows.push_back(row_reg(REG_TARGET_COUNT, 2));
    rows.push_back(row_reg(REG_OFFSET_COUNT, 2));
    rows.push_back(row_query(0, 0));                         // exact hit on first offset
    rows.push_back(row_query(4, 1));                         // falls between offsets
    rows.push_back(row_query('hFFFFF, 1));                   // largest path, last row
    rows.push_back(row_query(7, DEPTH - 1, 1'b1));           // batch position past targets
    rows.push_back(row_reg(REG_MODE, int'(MODE_DIRECTED)));
    rows.push_back(row_query(0, 0));
    rows.push_back(row_query(1, 0));
    rows.push_back(row_query(2, 0, 1'b1));                   // start index past count
    rows.push_back(row_reg(REG_START_COUNT, 1));
    rows.push_back(row_query(0, 0, 1'b1));                   // zero divisor
    rows.push_back(row_reg(REG_START_COUNT, 2));
    rows.push_back(row_reg(REG_MODE, int'(MODE_UNDIRECTED)));
    rows.push_back(row_reg(REG_OFFSET_COUNT, 1));
    rows.push_back(row_query(0, 0));
    rows.push_back(row_query(1, 0, 1'b1));                   // target index past count
    rows.push_back(row_reg(REG_OFFSET_COUNT, 0));
    rows.push_back(row_query(0, 0, 1'b1));                   // no offsets: search finds no row
    rows.push_back(row_reg(REG_MODE, int'(MODE_GRID)));
    rows.push_back(row_reg(REG_TARGET_COUNT, 0));
    rows.push_back(row_query(3, 0, 1'b1));                   // grid with no targets
    rows.push_back(row_reg(REG_TARGET_COUNT, 2));
    rows.push_back(row_query(3, 0));
    rows.push_back(row_query(4, 0, 1'b1));                   // past the last grid cell
    rows.push_back(row_reg(REG_MODE, int'(MODE_PAIRWISE)));
    rows.push_back(row_reg(REG_OFFSET_COUNT, 2));
    rows.push_back(row_load(CMD_LOAD_OFFSET, 0, 3));
    rows.push_back(row_load(CMD_LOAD_OFFSET, 1, 3));
    rows.push_back(row_query(3, 1));                         // equal offsets, first hit probed
    rows.push_back(row_query(2, 0, 1'b1));                   // path below the first offset
    // start count beyond the depth clips to it
    rows.push_back(row_reg(REG_MODE, int'(MODE_GRID)));
    rows.push_back(row_reg(REG_START_COUNT, 2047));
    rows.push_back(row_reg(REG_TARGET_COUNT, 1));
    rows.push_back(row_query(DEPTH - 1, 0));                 // last start row
    rows.push_back(row_query(DEPTH, 0, 1'b1));               // first row past the depth
    rows.push_back(row_reg(REG_MODE, int'(MODE_DIRECTED)));
    rows.push_back(row_query((DEPTH - 1) * (DEPTH - 1), 0)); // last start row
    rows.push_back(row_query((DEPTH - 1) * DEPTH, 0, 1'b1));  // first row past the depth

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        wait_idle();
        reg_write(rows[i].reg_id, rows[i].reg_value);
      end else begin
        offer(rows[i].item, rows[i].flagged);
      end
    end

    // Random phases: idling pattern and mode rotate so every pairing occurs.
    // Pairwise and undirected phases mostly load sorted offsets; loads mid-phase add noise.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1:       begin tx_idle_pct = 53; rx_idle_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_idle_pct = 53; end
        default: begin tx_idle_pct = 12; rx_idle_pct = 12; end
      endcase
      pm = mode_t'((ph + ph / 4) % 4);

      // size class: 0 degenerate counts, 1 small
      sel = $urandom_range(0, 9);
      cls = (sel == 0) ? 0 : 1;
      if (ph == 13) cls = 0;

      if (cls == 0) begin
        cnt_s = $urandom_range(0, 2);
        cnt_t = $urandom_range(0, 2);
        cnt_o = $urandom_range(0, 2);
      end else begin
        n     = $urandom_range(2, 40);
        cnt_s = n;
        cnt_t = ($urandom_range(0, 1) != 0) ? n : $urandom_range(1, n);
        case (pm)
          MODE_PAIRWISE:   cnt_o = n;
          MODE_UNDIRECTED: cnt_o = ($urandom_range(0, 1) != 0) ? clip_count(11'(n)) - 1 : n;
          default:         cnt_o = $urandom_range(0, n);
        endcase
      end
      shaped = (cls != 0) && (pm == MODE_PAIRWISE || pm == MODE_UNDIRECTED)
               && ($urandom_range(0, 5) != 0);

      reg_write(REG_MODE, int'(pm));
      reg_write(REG_START_COUNT, cnt_s);
      reg_write(REG_TARGET_COUNT, cnt_t);
      reg_write(REG_OFFSET_COUNT, cnt_o);
      eff_s = clip_count(11'(cnt_s));
      eff_t = clip_count(11'(cnt_t));
      eff_o = clip_count(11'(cnt_o));

      // Offsets: pairwise rows of random length (zero length gives equal
      // offsets), undirected rows of the triangular layout. Junk above bit 19.
      span = 64;
      if (shaped) begin
        base = 0;
        for (int i = 0; i < eff_o; i++) begin
          offer(load_item(CMD_LOAD_OFFSET, i,
                          base | ($urandom_range(0, 1) != 0 ? ($urandom_range(0, 2047) << 20) : 0)),
                1'b0);
          base += (pm == MODE_PAIRWISE) ? $urandom_range(0, 6) : eff_s - 1 - i;
        end
        span = base;
      end else begin
        fill_unwritten(CMD_LOAD_OFFSET, eff_o);
      end
      fill_unwritten(CMD_LOAD_START, eff_s);
      fill_unwritten(CMD_LOAD_TARGET, eff_t);
      if (pm == MODE_DIRECTED) span = eff_s * (eff_s - 1);
      if (pm == MODE_GRID) span = eff_s * eff_t;
      if (span < 4) span = 4;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // receiver holds off for a long stretch while the sender keeps going
        if (k == 8 && (ph == 1 || ph == 8)) hold_req++;
        if ($urandom_range(0, 9) < 7) begin
          p = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, span + 2);
          b = (pm == MODE_PAIRWISE && $urandom_range(0, 4) != 0) ?
              $urandom_range(0, eff_t) : $urandom;
          offer(query_item(p, b), 1'b0);
        end else begin
          sel = $urandom_range(0, 19);
          lc  = (sel == 0) ? CMD_LOAD_OFFSET : (sel < 10) ? CMD_LOAD_START : CMD_LOAD_TARGET;
          offer(load_item(lc, ($urandom_range(0, 1) != 0) ? $urandom_range(0, DEPTH - 1)
                                                          : $urandom_range(0, 63),
                          $urandom), 1'b0);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pitep_pkg.sv
rtl/core/pitep_ram.sv
rtl/core/pitep_div.sv
rtl/core/path_index_to_endpoint_pair_unit.sv
tb/path_index_to_endpoint_pair_unit_tb.sv
